### hdl/murmur2_64bit_hash_defines.svh
// Assertion macros used by the checker in mm2_checker.sv.
`ifndef MURMUR2_64BIT_HASH_DEFINES_SVH
`define MURMUR2_64BIT_HASH_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MM2_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the next edge.
`define MM2_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mm2_pkg.sv
`timescale 1ns / 1ps

package mm2_pkg;

    localparam logic [63:0] MixMul   = 64'hc6a4a7935bd1e995;
    localparam int          MixShift = 47;
    localparam int          DigitW   = 4;
    localparam int          NumDigit = 64 / DigitW;

    typedef logic [63:0]       word_t;
    typedef logic [DigitW-1:0] digit_t;

    function automatic word_t mul_digit(input digit_t d);
        word_t prod;
        prod = MixMul * word_t'(d);
        return prod;
    endfunction

    function automatic word_t xor_shift(input word_t w);
        word_t r;
        r = w ^ (w >> MixShift);
        return r;
    endfunction

endpackage

### hdl/mm2_mul.sv
`timescale 1ns / 1ps

module mm2_mul
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  mm2_pkg::word_t      opnd,
    output logic                done,
    output mm2_pkg::word_t      result
);

    localparam int CntW = $clog2(mm2_pkg::NumDigit);

    mm2_pkg::word_t opnd_reg, opnd_next;
    mm2_pkg::word_t acc_reg, acc_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    always_comb
    begin
        opnd_next = opnd_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            opnd_next = opnd;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // fold in the top digit, most significant first
            acc_next  = (acc_reg << mm2_pkg::DigitW)
                        + mm2_pkg::mul_digit(opnd_reg[63 -: mm2_pkg::DigitW]);
            opnd_next = opnd_reg << mm2_pkg::DigitW;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(mm2_pkg::NumDigit - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opnd_reg <= opnd_next;
        acc_reg  <= acc_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

### hdl/murmur2_64bit_hash.sv
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_*       in         tdata: data_word, byte_count, message_length; tlast: last_item
// m_*       out        tdata: hash_value
// cfg_*     in         data: hash_seed
//
// One item at a time. Each 64-bit multiplication by the mix constant runs on a shared 4-bit
// digit-serial multiplier; an item needs 1 to 5 of them (first-item seeding, full-word mix
// of three, tail fold of one, final avalanche of one). Reset clears the seed and message state.
// The result waits in an output register; a stalled output holds the block in its
// last step only when the next hash is finished.

module murmur2_64bit_hash
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,   // data_word[63:0], byte_count[67:64],
                                     // message_length[98:68], zero pad
    input  logic          s_tlast,   // last_item
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // hash_value
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   cfg_data   // hash_seed
);

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StLoad = 3'd1;
    localparam logic [2:0] StSeed = 3'd2;
    localparam logic [2:0] StMixA = 3'd3;
    localparam logic [2:0] StMixB = 3'd4;
    localparam logic [2:0] StHMul = 3'd5;
    localparam logic [2:0] StAval = 3'd6;
    localparam logic [2:0] StFin  = 3'd7;

    logic [2:0]     state_reg, state_next;
    logic           in_msg_reg, in_msg_next;
    logic [31:0]    seed_reg, seed_next;
    logic           out_valid_reg, out_valid_next;
    mm2_pkg::word_t out_data_reg, out_data_next;
    mm2_pkg::word_t h_reg, h_next;
    mm2_pkg::word_t t_reg, t_next;
    mm2_pkg::word_t word_reg, word_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic [30:0]    len_reg, len_next;
    logic           last_reg, last_next;

    logic           mul_start;
    mm2_pkg::word_t mul_opnd;
    logic           mul_done;
    mm2_pkg::word_t mul_res;

    logic           dispatch;
    mm2_pkg::word_t h_cur;
    mm2_pkg::word_t mask;
    logic           full_word;
    logic           tail_word;

    mm2_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .opnd   (mul_opnd),
        .done   (mul_done),
        .result (mul_res)
    );

    assign full_word = !last_reg || (cnt_reg == 4'd8);
    assign tail_word = last_reg && (cnt_reg != 4'd0) && (cnt_reg != 4'd8);
    assign mask      = (64'd1 << {cnt_reg[2:0], 3'b000}) - 64'd1;

    always_comb
    begin
        state_next     = state_reg;
        in_msg_next    = in_msg_reg;
        seed_next      = seed_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        h_next         = h_reg;
        t_next         = t_reg;
        word_next      = word_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        mul_start      = 1'b0;
        mul_opnd       = '0;
        dispatch       = 1'b0;
        h_cur          = h_reg;

        if (cfg_valid)
        begin
            seed_next = cfg_data;
        end
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            StIdle:
            begin
                if (s_tvalid)
                begin
                    word_next  = s_tdata[63:0];
                    cnt_next   = (s_tdata[67:64] > 4'd8) ? 4'd8 : s_tdata[67:64];
                    len_next   = s_tdata[98:68];
                    last_next  = s_tlast;
                    state_next = StLoad;
                end
            end
            StLoad:
            begin
                if (!in_msg_reg)
                begin
                    mul_start  = 1'b1;
                    mul_opnd   = {33'b0, len_reg};
                    state_next = StSeed;
                end
                else
                begin
                    dispatch = 1'b1;
                end
            end
            StSeed:
            begin
                if (mul_done)
                begin
                    h_cur    = {32'b0, seed_reg} ^ mul_res;
                    dispatch = 1'b1;
                end
            end
            StMixA:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_opnd   = mm2_pkg::xor_shift(mul_res);
                    state_next = StMixB;
                end
            end
            StMixB:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_opnd   = h_reg ^ mul_res;
                    state_next = StHMul;
                end
            end
            StHMul:
            begin
                if (mul_done)
                begin
                    if (last_reg)
                    begin
                        mul_start  = 1'b1;
                        mul_opnd   = mm2_pkg::xor_shift(mul_res);
                        state_next = StAval;
                    end
                    else
                    begin
                        h_next      = mul_res;
                        in_msg_next = 1'b1;
                        state_next  = StIdle;
                    end
                end
            end
            StAval:
            begin
                if (mul_done)
                begin
                    t_next     = mm2_pkg::xor_shift(mul_res);
                    state_next = StFin;
                end
            end
            StFin:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = t_reg;
                    h_next         = '0;
                    in_msg_next    = 1'b0;
                    state_next     = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase

        if (dispatch)
        begin
            h_next    = h_cur;
            mul_start = 1'b1;
            priority if (full_word)
            begin
                mul_opnd   = word_reg;
                state_next = StMixA;
            end
            else if (tail_word)
            begin
                mul_opnd   = h_cur ^ (word_reg & mask);
                state_next = StHMul;
            end
            else
            begin
                mul_opnd   = mm2_pkg::xor_shift(h_cur);
                state_next = StAval;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= StIdle;
            in_msg_reg    <= 1'b0;
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
            h_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            in_msg_reg    <= in_msg_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        t_reg        <= t_next;
        word_reg     <= word_next;
        cnt_reg      <= cnt_next;
        len_reg      <= len_next;
        last_reg     <= last_next;
    end

    assign s_tready  = (state_reg == StIdle);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule

### hdl/mm2_checker.sv
`timescale 1ns / 1ps
`include "murmur2_64bit_hash_defines.svh"

module mm2_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata
);

    `MM2_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "output dropped while stalled")
    `MM2_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "output changed while stalled")
    `MM2_ASSERT_NEXT(a_in_busy, s_tvalid && s_tready, !s_tready, "input taken during item work")
    `MM2_ASSERT(a_out_after_work, $rose(m_tvalid) |-> $past(!s_tready), "result without item work")

endmodule

bind murmur2_64bit_hash mm2_checker u_mm2_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
